>>> hw/rtl/four_level_page_table_walker_assert.svh
// assertion macros shared by the page table walker rtl
// no dependencies; included by the controller and the datapath
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FLTW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FLTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fltw_pkg.sv
// shared types and constants of the four level page table walker
// no dependencies; used by the controller, the datapath and the top level
package fltw_pkg;

    // default number of 64-bit words in the table store
    localparam int STORE_WORDS_DEF = 4096;

    // field widths
    localparam int ENTRY_W = 64;
    localparam int INDEX_W = 12;
    localparam int PA_W    = 52;
    localparam int VA_KEEP = 39;   // va bits kept after the first read is issued
    localparam int WORD_W  = 62;   // word number of an entry, no wrap-around
    localparam int LVL_IDX = 9;

    // entry bit positions
    localparam int PRESENT_POS = 0;
    localparam int PS_POS      = 7;

    // request codes
    localparam logic REQ_LOAD      = 1'b0;
    localparam logic REQ_TRANSLATE = 1'b1;

    // table level being checked
    typedef enum logic [1:0] {
        LVL_1,
        LVL_2,
        LVL_3,
        LVL_4
    } level_t;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_L1,
        ST_L2,
        ST_L3,
        ST_L4
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic   clear;
        logic   load;
        logic   issue;
        logic   check;
        level_t level;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic walk_end;
    } stat_t;

endpackage

>>> hw/rtl/fltw_ctrl.sv
// controller state machine of the page table walker
// depends on fltw_pkg and the assertion macro header
`include "four_level_page_table_walker_assert.svh"

module fltw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           req_type,
    input  fltw_pkg::stat_t stat,
    output fltw_pkg::cmd_t  cmd,
    output logic           busy
);
    import fltw_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start && (req_type == REQ_TRANSLATE))
                begin
                    state_next = ST_L1;
                end
            end
            ST_L1:
            begin
                state_next = stat.walk_end ? ST_IDLE : ST_L2;
            end
            ST_L2:
            begin
                state_next = stat.walk_end ? ST_IDLE : ST_L3;
            end
            ST_L3:
            begin
                state_next = stat.walk_end ? ST_IDLE : ST_L4;
            end
            ST_L4:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd       = '0;
        cmd.level = LVL_1;
        busy      = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy      = 1'b0;
                cmd.load  = start && (req_type == REQ_LOAD);
                cmd.issue = start && (req_type == REQ_TRANSLATE);
            end
            ST_L1:
            begin
                cmd.check = 1'b1;
                cmd.level = LVL_1;
            end
            ST_L2:
            begin
                cmd.check = 1'b1;
                cmd.level = LVL_2;
            end
            ST_L3:
            begin
                cmd.check = 1'b1;
                cmd.level = LVL_3;
            end
            ST_L4:
            begin
                cmd.check = 1'b1;
                cmd.level = LVL_4;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // the leaf level always finishes the walk
    `FLTW_ASSERT_NEXT(a_leaf_returns_idle, clk, rst_n, state_reg == ST_L4,
        state_reg == ST_IDLE, "walk did not finish after the leaf level")
    // no transfer is taken during the clearing pass
    `FLTW_ASSERT_NOW(a_clear_blocks, clk, rst_n, state_reg == ST_CLEAR,
        busy && !cmd.load && !cmd.issue, "transfer taken while clearing")
    // an issued translation starts at the first level
    `FLTW_ASSERT_NEXT(a_issue_to_l1, clk, rst_n, cmd.issue,
        state_reg == ST_L1, "translation did not enter the first level")

endmodule

>>> hw/rtl/fltw_datapath.sv
// datapath of the page table walker: table store, entry checks, result register
// depends on fltw_pkg and the assertion macro header
`include "four_level_page_table_walker_assert.svh"

module fltw_datapath #(
    parameter int STORE_WORDS = fltw_pkg::STORE_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fltw_pkg::cmd_t                cmd,
    output fltw_pkg::stat_t               stat,
    input  logic [fltw_pkg::INDEX_W-1:0]  word_index,
    input  logic [fltw_pkg::ENTRY_W-1:0]  word_data,
    input  logic [fltw_pkg::ENTRY_W-1:0]  table_base,
    input  logic [fltw_pkg::ENTRY_W-1:0]  virtual_address,
    output logic                          done,
    output logic [fltw_pkg::PA_W-1:0]     phys_addr,
    output logic                          fault
);
    import fltw_pkg::*;

    localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam logic [WORD_W-1:0] STORE_LIMIT = WORD_W'(STORE_WORDS);
    localparam logic [AW-1:0]     LAST_WORD   = AW'(STORE_WORDS - 1);

    // table store
    logic [ENTRY_W-1:0] mem [STORE_WORDS];

    logic [AW-1:0]      clr_reg;
    logic [AW-1:0]      clr_next;
    logic [ENTRY_W-1:0] rdata_reg;
    logic               oob_reg;
    logic [VA_KEEP-1:0] va_reg;
    logic               done_reg;
    logic               done_next;
    logic               fault_reg;
    logic [PA_W-1:0]    pa_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               load_ok;

    logic [LVL_IDX-1:0] idx_next;
    logic [WORD_W-1:0]  rd_word;
    logic               rd_oob;
    logic               rd_en;

    logic               chk_fault;
    logic               chk_page;
    logic [PA_W-1:0]    chk_pa;

    // write port: clearing pass or load transfer
    always_comb
    begin
        load_ok = 32'(word_index) < 32'(STORE_WORDS);
        if (cmd.clear)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = cmd.load && load_ok;
            wr_addr = AW'(word_index);
            wr_data = word_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // clearing pass counter
    assign clr_next        = cmd.clear ? clr_reg + AW'(1) : clr_reg;
    assign stat.clear_last = cmd.clear && (clr_reg == LAST_WORD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
        end
    end

    // index of the next level's entry
    always_comb
    begin
        case (cmd.level)
            LVL_1:   idx_next = va_reg[38:30];
            LVL_2:   idx_next = va_reg[29:21];
            default: idx_next = va_reg[20:12];
        endcase
    end

    // entry word number and range check
    always_comb
    begin
        if (cmd.issue)
        begin
            rd_word = {1'b0, table_base[63:4], 1'b0}
                    + {{(WORD_W - LVL_IDX){1'b0}}, virtual_address[47:39]};
        end
        else
        begin
            rd_word = {{(WORD_W - 49){1'b0}}, rdata_reg[51:12], idx_next};
        end
        rd_oob = rd_word >= STORE_LIMIT;
    end

    // entry checks for the level in hand
    always_comb
    begin
        chk_fault = oob_reg || !rdata_reg[PRESENT_POS];
        chk_page  = 1'b0;
        chk_pa    = {rdata_reg[51:12], va_reg[11:0]};
        case (cmd.level)
            LVL_1:
            begin
                chk_page = 1'b0;
            end
            LVL_2:
            begin
                chk_page = rdata_reg[PS_POS];
                chk_pa   = {rdata_reg[51:30], va_reg[29:0]};
            end
            LVL_3:
            begin
                chk_page = rdata_reg[PS_POS];
                chk_pa   = {rdata_reg[51:21], va_reg[20:0]};
            end
            LVL_4:
            begin
                // leaf ignores the present bit; it faults only when out of range or when the whole entry is zero
                chk_fault = oob_reg || (rdata_reg == '0);
                chk_page  = 1'b1;
            end
            default:
            begin
                chk_page = 1'b1;
            end
        endcase
    end

    assign stat.walk_end = cmd.check && (chk_fault || chk_page);

    // read port: issue the first read or the next level's read
    assign rd_en = (cmd.issue || (cmd.check && !stat.walk_end)) && !rd_oob;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_word[AW-1:0]];
        end
    end

    // walk payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.issue || cmd.check)
        begin
            oob_reg <= rd_oob;
        end
        if (cmd.issue)
        begin
            va_reg <= virtual_address[VA_KEEP-1:0];
        end
        if (stat.walk_end)
        begin
            fault_reg <= chk_fault;
            pa_reg    <= chk_fault ? '0 : chk_pa;
        end
    end

    // result strobe
    assign done_next = stat.walk_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign fault     = fault_reg;
    assign phys_addr = pa_reg;

    // a result follows a level check
    `FLTW_ASSERT_NOW(a_done_after_check, clk, rst_n, done_reg, $past(cmd.check),
        "result strobe without a level check")
    // a faulting result carries a zero address
    `FLTW_ASSERT_NOW(a_fault_zero_pa, clk, rst_n, done_reg && fault_reg,
        pa_reg == '0, "faulting result with nonzero address")
    // an out-of-range read always ends the walk
    `FLTW_ASSERT_NOW(a_oob_ends_walk, clk, rst_n, cmd.check && oob_reg,
        stat.walk_end, "out-of-range read did not end the walk")

endmodule

>>> hw/rtl/four_level_page_table_walker.sv
// top level of the four level page table walker
// depends on fltw_pkg, fltw_ctrl and fltw_datapath
//
// channel   direction  transfer when        payload
// request   in         start && !busy       req_type, word_index, word_data,
//                                           table_base, virtual_address
// result    out        done (one cycle)     phys_addr, fault
//
// a load is written to the store and gives no result
// a translation issues its first read in the accepting cycle, then checks each
// level it reads (one to four) in turn, one state per level;
// one store read port allows one level per cycle
// the result shows for one cycle right after the last level check
// after reset a clearing pass zeroes every word of the store, busy high
// the receiver cannot stall; a new request is taken while a result shows
module four_level_page_table_walker #(
    parameter int STORE_WORDS = fltw_pkg::STORE_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic [fltw_pkg::INDEX_W-1:0]  word_index,
    input  logic [fltw_pkg::ENTRY_W-1:0]  word_data,
    input  logic [fltw_pkg::ENTRY_W-1:0]  table_base,
    input  logic [fltw_pkg::ENTRY_W-1:0]  virtual_address,
    output logic                          done,
    output logic [fltw_pkg::PA_W-1:0]     phys_addr,
    output logic                          fault
);
    import fltw_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // controller
    fltw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // datapath
    fltw_datapath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .word_index       (word_index),
        .word_data        (word_data),
        .table_base       (table_base),
        .virtual_address  (virtual_address),
        .done             (done),
        .phys_addr        (phys_addr),
        .fault            (fault)
    );

endmodule

>>> dv/testbench.sv
// self-checking testbench for the four level page table walker
// depends on fltw_pkg and four_level_page_table_walker; checks every result strobe
// in order against a prediction from its store copy or a directed row's value
`timescale 1ns / 1ps

module testbench;

    import fltw_pkg::*;

    localparam int          ITEM_TARGET = 1600;
    localparam int          PAUSE_EVERY = 400;
    localparam int          DRAIN_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 16;
    localparam int          MAX_REPORTS = 10;
    localparam int          TIMEOUT_NS  = 5_000_000;
    localparam logic [63:0] FRAME_4K    = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] FRAME_2M    = 64'h000F_FFFF_FFE0_0000;
    localparam logic [63:0] FRAME_1G    = 64'h000F_FFFF_C000_0000;
    localparam logic        CHECK_FIXED = 1'b1;
    localparam logic        CHECK_MODEL = 1'b0;

    typedef struct packed {
        logic [PA_W-1:0] pa;
        logic            flt;
    } walk_result_t;

    typedef struct packed {
        logic               req;
        logic [INDEX_W-1:0] idx;
        logic [63:0]        data;
        logic [63:0]        base;
        logic [63:0]        vaddr;
        logic               given;
        logic [PA_W-1:0]    pa;
        logic               flt;
    } walk_row_t;

    // directed rows: empty store, extremes, faults at levels one, two and four, each page size
    localparam walk_row_t DIRECTED_ROWS [26] = '{
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'h0, 64'h0, CHECK_FIXED, 52'h0, 1'b1},
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
          CHECK_FIXED, 52'h0, 1'b1},
        '{REQ_LOAD, 12'd0, 64'h1001, 64'h0, 64'h0, CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_LOAD, 12'd512, 64'h2001, 64'h0, 64'h0, CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_LOAD, 12'd1024, 64'h3001, 64'h0, 64'h0, CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'h0, 64'hABC, CHECK_FIXED, 52'h0, 1'b1},
        '{REQ_LOAD, 12'd1536, 64'h2, 64'h0, 64'h0, CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'h0, 64'hABC, CHECK_FIXED, 52'hABC, 1'b0},
        '{REQ_LOAD, 12'd1536, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0,
          CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'hF, 64'hFFFF_0000_0000_0ABC,
          CHECK_FIXED, 52'hF_FFFF_FFFF_FABC, 1'b0},
        '{REQ_LOAD, 12'd1024, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0,
          CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'h0, 64'hFFFF_0000_001F_FFFF,
          CHECK_FIXED, 52'hF_FFFF_FFFF_FFFF, 1'b0},
        '{REQ_LOAD, 12'd512, 64'h000F_FFFF_C000_0081, 64'h0, 64'h0,
          CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'h0, 64'h1234_5678,
          CHECK_FIXED, 52'hF_FFFF_D234_5678, 1'b0},
        '{REQ_LOAD, 12'd0, 64'h1081, 64'h0, 64'h0, CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'h0, 64'h3FFF_FFFF, CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_LOAD, 12'd0, 64'h1000, 64'h0, 64'h0, CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'h0, 64'h0, CHECK_FIXED, 52'h0, 1'b1},
        '{REQ_LOAD, 12'd0, 64'h8001, 64'h0, 64'h0, CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'h0, 64'h0, CHECK_FIXED, 52'h0, 1'b1},
        '{REQ_LOAD, 12'd0, 64'h1001, 64'h0, 64'h0, CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_LOAD, 12'd512, 64'h2080, 64'h0, 64'h0, CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'h0, 64'h0, CHECK_FIXED, 52'h0, 1'b1},
        '{REQ_LOAD, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0,
          CHECK_MODEL, 52'h0, 1'b0},
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'h7FF0, 64'h0000_0100_0000_0000,
          CHECK_FIXED, 52'h0, 1'b1},
        '{REQ_TRANSLATE, 12'd0, 64'h0, 64'h7FF0, 64'h0000_0080_0000_0000,
          CHECK_MODEL, 52'h0, 1'b0}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               req_type;
    logic [INDEX_W-1:0] word_index;
    logic [ENTRY_W-1:0] word_data;
    logic [ENTRY_W-1:0] table_base;
    logic [ENTRY_W-1:0] virtual_address;
    logic               done;
    logic [PA_W-1:0]    phys_addr;
    logic               fault;

    logic [63:0]  page_mem [STORE_WORDS_DEF];
    walk_result_t xlate_expect_q [$];
    logic [63:0]  recent_va [$];
    logic [63:0]  recent_base [$];
    int           mismatch_count = 0;
    int           items_sent = 0;
    bit           steady = 1'b0;

    four_level_page_table_walker u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req_type         (req_type),
        .word_index       (word_index),
        .word_data        (word_data),
        .table_base       (table_base),
        .virtual_address  (virtual_address),
        .done             (done),
        .phys_addr        (phys_addr),
        .fault            (fault)
    );

    // clock
    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // next-level table entry: present, frame inside the store, random spare bits
    function automatic logic [63:0] table_entry(input logic [2:0] frame);
        logic [63:0] ent;
        ent = rand64();
        ent[51:12] = '0;
        ent[14:12] = frame;
        ent[PS_POS] = 1'b0;
        ent[PRESENT_POS] = 1'b1;
        return ent;
    endfunction

    // table base whose top-level entry for this index lands inside the store
    function automatic logic [63:0] pick_base(input logic [8:0] top_idx);
        logic [63:0] word0;
        if ($urandom_range(1) == 1)
            word0 = 64'($urandom_range(7)) * 512;
        else
            word0 = 64'($urandom_range((4095 - top_idx) / 2)) * 2;
        return (word0 << 3) | 64'($urandom_range(15));
    endfunction

    // four-level walk over the local copy of the store
    function automatic void walk_tables(input logic [63:0] base, input logic [63:0] vaddr,
                                        output logic [PA_W-1:0] pa, output logic flt);
        logic [63:0] tab;
        logic [63:0] ent;
        logic [63:0] word;
        logic [63:0] sum;
        level_t      lvl_code;
        int          lvl;
        pa  = '0;
        flt = 1'b1;
        tab = base & ~64'hF;
        for (lvl = 0; lvl < 4; lvl++)
        begin
            lvl_code = level_t'(lvl);
            word = (tab >> 3) + ((vaddr >> (39 - 9 * lvl)) & 64'h1FF);
            if (word >= STORE_WORDS_DEF)
                return;
            ent = page_mem[word[INDEX_W-1:0]];
            // only an all-zero leaf faults; upper levels need the present bit
            if (lvl_code == LVL_4)
            begin
                if (ent == '0)
                    return;
                sum = (ent & FRAME_4K) + (vaddr & 64'hFFF);
                pa  = sum[PA_W-1:0];
                flt = 1'b0;
                return;
            end
            if (!ent[PRESENT_POS])
                return;
            // large pages end the walk early; level one ignores the size bit
            if (lvl_code == LVL_2 && ent[PS_POS])
            begin
                sum = (ent & FRAME_1G) + (vaddr & 64'h3FFF_FFFF);
                pa  = sum[PA_W-1:0];
                flt = 1'b0;
                return;
            end
            if (lvl_code == LVL_3 && ent[PS_POS])
            begin
                sum = (ent & FRAME_2M) + (vaddr & 64'h1F_FFFF);
                pa  = sum[PA_W-1:0];
                flt = 1'b0;
                return;
            end
            tab = ent & FRAME_4K;
        end
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // one request transfer, then update the store copy or queue the expected result
    task automatic issue_request(input logic req, input logic [INDEX_W-1:0] idx,
                                 input logic [63:0] data, input logic [63:0] base,
                                 input logic [63:0] vaddr, input logic given,
                                 input logic [PA_W-1:0] pa_given, input logic flt_given);
        walk_result_t res;
        if (!steady)
        begin
            while ($urandom_range(99) < 12)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start           <= 1'b1;
        req_type        <= req;
        word_index      <= idx;
        word_data       <= data;
        table_base      <= base;
        virtual_address <= vaddr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (req == REQ_LOAD)
        begin
            if (idx < STORE_WORDS_DEF)
                page_mem[idx] = data;
        end
        else
        begin
            if (given)
            begin
                res.pa  = pa_given;
                res.flt = flt_given;
            end
            else
            begin
                walk_tables(base, vaddr, res.pa, res.flt);
            end
            xlate_expect_q.push_back(res);
        end
    endtask

    // a well-formed walk for a random address, sometimes broken at one level,
    // followed by a few translations that follow it
    task automatic build_walk();
        logic [63:0] vaddr;
        logic [63:0] base;
        logic [63:0] ent;
        logic [63:0] word;
        logic [63:0] va2;
        logic [2:0]  frame;
        logic        leaf;
        int          lvl;
        int          brk_lvl;
        int          brk_kind;
        int          n;
        vaddr    = rand64();
        base     = pick_base(vaddr[47:39]);
        brk_lvl  = ($urandom_range(99) < 20) ? $urandom_range(1, 4) : 0;
        brk_kind = $urandom_range(2);
        word     = ((base & ~64'hF) >> 3) + vaddr[47:39];
        leaf     = 1'b0;
        for (lvl = 1; lvl <= 4 && !leaf; lvl++)
        begin
            frame = 3'($urandom_range(7));
            if (lvl == 4)
            begin
                ent = rand64();
            end
            else if (lvl > 1 && $urandom_range(99) < 25)
            begin
                ent = rand64();
                ent[PRESENT_POS] = 1'b1;
                ent[PS_POS] = 1'b1;
                leaf = 1'b1;
            end
            else
            begin
                ent = table_entry(frame);
                if (lvl == 1)
                    ent[PS_POS] = 1'($urandom_range(1));
            end
            // breakage: not present or zero leaf, frame outside the store, or missing
            if (lvl == brk_lvl)
            begin
                if (brk_kind == 0)
                begin
                    if (lvl == 4)
                        ent = '0;
                    else
                        ent[PRESENT_POS] = 1'b0;
                end
                else if (brk_kind == 1)
                begin
                    ent[51:15] = 37'({$urandom, $urandom}) | 37'd1;
                end
            end
            if (!(lvl == brk_lvl && brk_kind == 2))
                issue_request(REQ_LOAD, word[INDEX_W-1:0], ent, rand64(), rand64(),
                              CHECK_MODEL, '0, 1'b0);
            word = 64'(frame) * 512 + ((vaddr >> (39 - 9 * lvl)) & 64'h1FF);
        end
        recent_va.push_back(vaddr);
        recent_base.push_back(base);
        if (recent_va.size() > 16)
        begin
            void'(recent_va.pop_front());
            void'(recent_base.pop_front());
        end
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            va2 = vaddr;
            va2[11:0]  = 12'($urandom);
            va2[63:48] = 16'($urandom);
            issue_request(REQ_TRANSLATE, INDEX_W'($urandom), rand64(),
                          base ^ 64'($urandom_range(15)), va2, CHECK_MODEL, '0, 1'b0);
        end
    endtask

    // result checking; results cannot be held off
    always @(posedge clk)
    begin : result_check
        walk_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (xlate_expect_q.size() == 0)
            begin
                log_mismatch($sformatf("result with none expected: pa=%h fault=%b",
                                       phys_addr, fault));
            end
            else
            begin
                want = xlate_expect_q.pop_front();
                if (phys_addr !== want.pa || fault !== want.flt)
                    log_mismatch($sformatf("expected pa=%h fault=%b, got pa=%h fault=%b",
                                           want.pa, want.flt, phys_addr, fault));
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        logic [63:0] vaddr;
        logic [63:0] base;
        logic [63:0] data;
        int          r;
        int          i;
        int          next_pause;
        int          drain;
        for (i = 0; i < STORE_WORDS_DEF; i++)
            page_mem[i] = '0;
        rst_n           <= 1'b0;
        start           <= 1'b0;
        req_type        <= REQ_LOAD;
        word_index      <= '0;
        word_data       <= '0;
        table_base      <= '0;
        virtual_address <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (DIRECTED_ROWS[k])
            issue_request(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].idx, DIRECTED_ROWS[k].data,
                          DIRECTED_ROWS[k].base, DIRECTED_ROWS[k].vaddr,
                          DIRECTED_ROWS[k].given, DIRECTED_ROWS[k].pa,
                          DIRECTED_ROWS[k].flt);

        // random mix, mostly well-formed walks
        next_pause = PAUSE_EVERY;
        while (items_sent < ITEM_TARGET)
        begin
            steady = (items_sent >= 600 && items_sent < 900);
            r = $urandom_range(99);
            if (r < 55)
            begin
                build_walk();
            end
            else if (r < 75)
            begin
                if (recent_va.size() != 0 && $urandom_range(1) == 1)
                begin
                    i = $urandom_range(recent_va.size() - 1);
                    vaddr = recent_va[i];
                    vaddr[11:0] = 12'($urandom);
                    if ($urandom_range(1) == 1)
                        vaddr[20:12] = 9'($urandom);
                    base = recent_base[i];
                end
                else
                begin
                    vaddr = rand64();
                    base  = pick_base(vaddr[47:39]);
                end
                issue_request(REQ_TRANSLATE, INDEX_W'($urandom), rand64(), base, vaddr,
                              CHECK_MODEL, '0, 1'b0);
            end
            else if (r < 87)
            begin
                case ($urandom_range(2))
                    0:       data = rand64();
                    1:       data = table_entry(3'($urandom_range(7)));
                    default: data = '0;
                endcase
                issue_request(REQ_LOAD, INDEX_W'($urandom), data, rand64(), rand64(),
                              CHECK_MODEL, '0, 1'b0);
            end
            else
            begin
                issue_request(REQ_TRANSLATE, INDEX_W'($urandom), rand64(), rand64(),
                              rand64(), CHECK_MODEL, '0, 1'b0);
            end
            // sender holds off until every outstanding result has come back
            if (items_sent >= next_pause)
            begin
                next_pause += PAUSE_EVERY;
                start <= 1'b0;
                do
                    @(posedge clk);
                while (xlate_expect_q.size() != 0);
            end
        end
        start <= 1'b0;

        // drain outstanding results up to a limit, then a quiet tail
        drain = 0;
        while (xlate_expect_q.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (xlate_expect_q.size() != 0)
            log_mismatch($sformatf("%0d expected results never arrived",
                                   xlate_expect_q.size()));

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
